// ===== rtl/lfurng_pkg.sv =====
// Package for the lagged-Fibonacci uniform generator: constants, register
// indexes and the small constant-modulus reducer used by the seed sequencer.
// No dependencies.
package lfurng_pkg;

    localparam int unsigned TableLen = 97;
    localparam int unsigned IdxW     = 7;
    localparam int unsigned WordW    = 24;
    localparam int unsigned ScaleW   = 31;
    localparam int unsigned SeedW    = 8;
    localparam int unsigned BitCntW  = 5;
    localparam int unsigned ProdW    = ScaleW + WordW;
    localparam int unsigned RedW     = 15;

    localparam logic [IdxW-1:0]  LagLong     = 7'd97;
    localparam logic [IdxW-1:0]  LagShort    = 7'd33;
    localparam logic [IdxW-1:0]  LastWord    = 7'd96;
    localparam logic [BitCntW-1:0] LastBit   = 5'd23;

    localparam logic [WordW-1:0] CarryInit   = 24'd362436;
    localparam logic [WordW-1:0] CarryDec    = 24'd7654321;
    localparam logic [WordW-1:0] CarryWrap   = 24'd9122892;  // modulus minus decrement

    localparam logic [SeedW-1:0] ModA        = 8'd179;
    localparam logic [SeedW-1:0] ModB        = 8'd169;
    localparam logic [SeedW-1:0] ModSeedA    = 8'd178;
    localparam logic [SeedW-1:0] MulB        = 8'd53;

    localparam logic [SeedW-1:0] RstSeedA1   = 8'd11;
    localparam logic [SeedW-1:0] RstSeedA2   = 8'd33;
    localparam logic [SeedW-1:0] RstSeedA3   = 8'd55;
    localparam logic [SeedW-1:0] RstSeedB    = 8'd78;

    typedef enum logic [1:0] {
        REG_SEED_A1 = 2'd0,
        REG_SEED_A2 = 2'd1,
        REG_SEED_A3 = 2'd2,
        REG_SEED_B  = 2'd3
    } t_reg_idx;

    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    // Remainder of a product below 256*m by restoring compare-subtract.
    function automatic logic [SeedW-1:0] mod_small(input logic [RedW-1:0] x,
                                                   input logic [SeedW-1:0] m);
        logic [RedW-1:0] rem;
        logic [RedW-1:0] sub;
        rem = x;
        for (int k = SeedW - 1; k >= 0; k--) begin
            sub = RedW'({m, 7'd0} >> (SeedW - 1 - k));
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[SeedW-1:0];
    endfunction

endpackage

// ===== rtl/lagged_fibonacci_uniform_rng.sv =====
// Top level of the lagged-Fibonacci (lags 97/33) uniform generator with an
// arithmetic sequence modulo 16777213; seed fill and draw share one multiplier.
// Depends on lfurng_pkg.
//
// Draw beat: table read, combine/write, scale multiply, output load; the input
// stalls until the beat is done, and the load waits while a full output is stalled.
// Reseed beat: fills 97 words x 24 bits through the one shared multiplier and the
// constant-modulus reducer, with no result.
// Reset (synchronous, active low): seeds to 11/33/55/78, lag table reads as zero
// through per-entry valid bits, indices 97/33, carry 362436. No clearing pass.
module lagged_fibonacci_uniform_rng (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [lfurng_pkg::ScaleW-1:0]     i_scale,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lfurng_pkg::WordW-1:0]      o_uniform_value,
    output logic [lfurng_pkg::ScaleW-1:0]     o_scaled_value,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int unsigned IdxW  = lfurng_pkg::IdxW;
    localparam int unsigned WordW = lfurng_pkg::WordW;
    localparam int unsigned SeedW = lfurng_pkg::SeedW;
    localparam int unsigned ProdW = lfurng_pkg::ProdW;
    localparam int unsigned ScaleW = lfurng_pkg::ScaleW;

    // Sequencer: multiply/reduce states for each table bit, then the bit shift
    // itself; a draw runs through read, calc, multiply and output states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_MUL1,    // a1 * a2
        S_SEED_RED1,    // mod 179
        S_SEED_MUL2,    // (a1*a2 mod 179) * a3
        S_SEED_RED2,    // mod 179, rotate the three seeds
        S_SEED_MULB,    // 53 * b + 1
        S_SEED_REDB,    // mod 169
        S_SEED_MULF,    // b * fresh
        S_SEED_BIT,     // shift product bit 5 into the word
        S_DRAW_RD,      // table read at both lags
        S_DRAW_CALC,    // subtract, write back, advance carry
        S_DRAW_MUL,     // scale * u
        S_DRAW_OUT      // load output register
    } t_state;

    t_state                  r_state;
    logic [SeedW-1:0]        r_seed_a1, r_seed_a2, r_seed_a3, r_seed_b;
    logic [SeedW-1:0]        r_a1, r_a2, r_a3, r_b, r_t;
    logic [WordW-1:0]        r_acc;
    logic [lfurng_pkg::BitCntW-1:0] r_bit_cnt;
    logic [IdxW-1:0]         r_word;
    logic [IdxW-1:0]         r_i, r_j;
    logic [WordW-1:0]        r_carry;
    logic [WordW-1:0]        r_u;
    logic [ScaleW-1:0]       r_scale;
    logic [ProdW-1:0]        r_prod;
    logic                    r_tab_vld [lfurng_pkg::TableLen];
    logic                    r_vld_i, r_vld_j;
    logic [WordW-1:0]        r_rd_i, r_rd_j;
    logic [WordW-1:0]        r_lag_mem [lfurng_pkg::TableLen];
    logic                    r_out_valid;
    logic [WordW-1:0]        r_out_uniform;
    logic [ScaleW-1:0]       r_out_scaled;

    // ------------------------------------------------------------------
    // Configuration port: zero-wait, write on the access phase.
    // ------------------------------------------------------------------
    logic                    cfg_wr;
    logic [1:0]              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            lfurng_pkg::REG_SEED_A1: prdata = {24'd0, r_seed_a1};
            lfurng_pkg::REG_SEED_A2: prdata = {24'd0, r_seed_a2};
            lfurng_pkg::REG_SEED_A3: prdata = {24'd0, r_seed_a3};
            lfurng_pkg::REG_SEED_B:  prdata = {24'd0, r_seed_b};
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Seed reduction at the start of a reseed beat (registers are 8 bits,
    // so one conditional subtract suffices for either modulus).
    // ------------------------------------------------------------------
    logic [SeedW-1:0] red_a1, red_a2, red_a3, red_b, start_a1;

    always_comb begin
        red_a1 = ((r_seed_a1 >= lfurng_pkg::ModSeedA) ? r_seed_a1 - lfurng_pkg::ModSeedA
                                                      : r_seed_a1) + 8'd1;
        red_a2 = ((r_seed_a2 >= lfurng_pkg::ModSeedA) ? r_seed_a2 - lfurng_pkg::ModSeedA
                                                      : r_seed_a2) + 8'd1;
        red_a3 = ((r_seed_a3 >= lfurng_pkg::ModSeedA) ? r_seed_a3 - lfurng_pkg::ModSeedA
                                                      : r_seed_a3) + 8'd1;
        red_b  = (r_seed_b >= lfurng_pkg::ModB) ? r_seed_b - lfurng_pkg::ModB : r_seed_b;
        // all three multiplicative seeds at one would give a dead sequence
        if (red_a1 == 8'd1 && red_a2 == 8'd1 && red_a3 == 8'd1) begin
            start_a1 = red_a1 + red_b;
        end else begin
            start_a1 = red_a1;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operand select by sequencer state.
    // ------------------------------------------------------------------
    logic [ScaleW-1:0]  mul_x;
    logic [WordW-1:0]   mul_y;
    logic               mul_c;
    logic [ProdW-1:0]   mul_p;

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        mul_c = 1'b0;
        case (r_state)
            S_SEED_MUL1: begin
                mul_x = ScaleW'(r_a1);
                mul_y = WordW'(r_a2);
            end
            S_SEED_MUL2: begin
                mul_x = ScaleW'(r_t);
                mul_y = WordW'(r_a3);
            end
            S_SEED_MULB: begin
                mul_x = ScaleW'(lfurng_pkg::MulB);
                mul_y = WordW'(r_b);
                mul_c = 1'b1;
            end
            S_SEED_MULF: begin
                mul_x = ScaleW'(r_b);
                mul_y = WordW'(r_a3);
            end
            S_DRAW_MUL: begin
                mul_x = r_scale;
                mul_y = r_u;
            end
            default: begin
                mul_x = '0;
            end
        endcase
        mul_p = ProdW'(mul_x) * ProdW'(mul_y) + ProdW'(mul_c);
    end

    // Shared reducer: modulus 169 only for the b recurrence.
    logic [SeedW-1:0] red_mod, red_out;

    assign red_mod = (r_state == S_SEED_REDB) ? lfurng_pkg::ModB : lfurng_pkg::ModA;
    assign red_out = lfurng_pkg::mod_small(r_prod[lfurng_pkg::RedW-1:0], red_mod);

    // ------------------------------------------------------------------
    // Draw datapath.
    // ------------------------------------------------------------------
    logic [IdxW-1:0]  slot_i, slot_j;
    logic [IdxW-1:0]  step_i, step_j;
    logic [WordW-1:0] lag_i, lag_j, lag_diff;
    logic [WordW-1:0] carry_next, uni_next;
    logic [WordW-1:0] acc_next;

    assign slot_i   = r_i - 7'd1;
    assign slot_j   = r_j - 7'd1;
    assign step_i   = (r_i <= 7'd1) ? lfurng_pkg::LagLong : r_i - 7'd1;
    assign step_j   = (r_j <= 7'd1) ? lfurng_pkg::LagLong : r_j - 7'd1;
    // entries never written since reset read as zero
    assign lag_i    = r_vld_i ? r_rd_i : '0;
    assign lag_j    = r_vld_j ? r_rd_j : '0;
    // subtract modulo 2^24 is a plain wrapping subtract
    assign lag_diff = lag_i - lag_j;
    assign carry_next = (r_carry >= lfurng_pkg::CarryDec) ? r_carry - lfurng_pkg::CarryDec
                                                          : r_carry + lfurng_pkg::CarryWrap;
    assign uni_next = lag_diff - carry_next;
    assign acc_next = {r_acc[WordW-2:0], r_prod[5]};

    // Table write port: one address per cycle.
    logic             mem_we;
    logic [IdxW-1:0]  mem_waddr;
    logic [WordW-1:0] mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_i;
        mem_wdata = lag_diff;
        case (r_state)
            S_DRAW_CALC: begin
                mem_we = 1'b1;
            end
            S_SEED_BIT: begin
                mem_we    = (r_bit_cnt == lfurng_pkg::LastBit);
                mem_waddr = r_word;
                mem_wdata = acc_next;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Lag table: one write port, two registered read ports at the lag slots.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_lag_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_i <= r_lag_mem[slot_i];
        r_rd_j <= r_lag_mem[slot_j];
    end

    logic out_take, in_take;

    assign out_take    = r_out_valid & ~i_out_stall;
    assign in_take     = i_in_valid & ~o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_uniform_value = r_out_uniform;
    assign o_scaled_value  = r_out_scaled;

    // ------------------------------------------------------------------
    // Sequencer, state registers and the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed_a1   <= lfurng_pkg::RstSeedA1;
            r_seed_a2   <= lfurng_pkg::RstSeedA2;
            r_seed_a3   <= lfurng_pkg::RstSeedA3;
            r_seed_b    <= lfurng_pkg::RstSeedB;
            r_i         <= lfurng_pkg::LagLong;
            r_j         <= lfurng_pkg::LagShort;
            r_carry     <= lfurng_pkg::CarryInit;
            r_bit_cnt   <= '0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < lfurng_pkg::TableLen; k++) begin
                r_tab_vld[k] <= 1'b0;
            end
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    lfurng_pkg::REG_SEED_A1: r_seed_a1 <= pwdata[SeedW-1:0];
                    lfurng_pkg::REG_SEED_A2: r_seed_a2 <= pwdata[SeedW-1:0];
                    lfurng_pkg::REG_SEED_A3: r_seed_a3 <= pwdata[SeedW-1:0];
                    lfurng_pkg::REG_SEED_B:  r_seed_b  <= pwdata[SeedW-1:0];
                    default: ;
                endcase
            end

            if (mem_we) begin
                r_tab_vld[mem_waddr] <= 1'b1;
            end

            // drop the result once taken; a new load below overrides
            if (out_take) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_scale <= i_scale;
                        if (i_func == lfurng_pkg::FUNC_DRAW) begin
                            r_state <= S_DRAW_RD;
                        end else begin
                            r_a1      <= start_a1;
                            r_a2      <= red_a2;
                            r_a3      <= red_a3;
                            r_b       <= red_b;
                            r_acc     <= '0;
                            r_bit_cnt <= '0;
                            r_word    <= '0;
                            r_i       <= lfurng_pkg::LagLong;
                            r_j       <= lfurng_pkg::LagShort;
                            r_carry   <= lfurng_pkg::CarryInit;
                            r_state   <= S_SEED_MUL1;
                        end
                    end
                end
                S_SEED_MUL1: begin
                    r_prod  <= mul_p;
                    r_state <= S_SEED_RED1;
                end
                S_SEED_RED1: begin
                    r_t     <= red_out;
                    r_state <= S_SEED_MUL2;
                end
                S_SEED_MUL2: begin
                    r_prod  <= mul_p;
                    r_state <= S_SEED_RED2;
                end
                S_SEED_RED2: begin
                    // rotate: the fresh value enters as the third seed
                    r_a1    <= r_a2;
                    r_a2    <= r_a3;
                    r_a3    <= red_out;
                    r_state <= S_SEED_MULB;
                end
                S_SEED_MULB: begin
                    r_prod  <= mul_p;
                    r_state <= S_SEED_REDB;
                end
                S_SEED_REDB: begin
                    r_b     <= red_out;
                    r_state <= S_SEED_MULF;
                end
                S_SEED_MULF: begin
                    r_prod  <= mul_p;
                    r_state <= S_SEED_BIT;
                end
                S_SEED_BIT: begin
                    // product mod 64 above 31 is bit 5 of the product
                    r_acc <= acc_next;
                    if (r_bit_cnt == lfurng_pkg::LastBit) begin
                        r_bit_cnt <= '0;
                        r_acc     <= '0;
                        if (r_word == lfurng_pkg::LastWord) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_word  <= r_word + 7'd1;
                            r_state <= S_SEED_MUL1;
                        end
                    end else begin
                        r_bit_cnt <= r_bit_cnt + 5'd1;
                        r_state   <= S_SEED_MUL1;
                    end
                end
                S_DRAW_RD: begin
                    r_vld_i <= r_tab_vld[slot_i];
                    r_vld_j <= r_tab_vld[slot_j];
                    r_state <= S_DRAW_CALC;
                end
                S_DRAW_CALC: begin
                    r_carry <= carry_next;
                    r_u     <= uni_next;
                    r_i     <= step_i;
                    r_j     <= step_j;
                    r_state <= S_DRAW_MUL;
                end
                S_DRAW_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_DRAW_OUT;
                end
                S_DRAW_OUT: begin
                    // hold until the output register is free or being emptied
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_out_uniform <= r_u;
                        r_out_scaled  <= r_prod[ProdW-1:WordW];
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Lag indices stay within the table.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i >= 7'd1 && r_i <= lfurng_pkg::LagLong &&
         r_j >= 7'd1 && r_j <= lfurng_pkg::LagLong))
        else $error("lag index out of range");

    // The two lags keep a fixed distance of 64 modulo 97.
    a_idx_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_i == r_j + 7'd64) || (r_j == r_i + 7'd33)))
        else $error("lag indices lost their spacing");

    // Fill counters never run past the table or the word.
    a_fill_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_cnt <= lfurng_pkg::LastBit && r_word <= lfurng_pkg::LastWord))
        else $error("fill counter overrun");

    // A completed draw always leaves a result pending.
    a_draw_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW_OUT && (!r_out_valid || !i_out_stall)) |=>
        (r_out_valid && r_state == S_IDLE))
        else $error("draw result not loaded");

endmodule

// ===== test/lfurng_draw_checker.sv =====
// Draw checker for the lagged-Fibonacci uniform generator: tracks seed writes,
// predicts every draw beat and compares the result channel against it.
// Depends on lfurng_pkg for port widths, register indexes and function codes.
module lfurng_draw_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_func,
    input  logic [lfurng_pkg::ScaleW-1:0] i_scale,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [lfurng_pkg::WordW-1:0]  i_uniform_value,
    input  logic [lfurng_pkg::ScaleW-1:0] i_scaled_value,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [3:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic                          i_pready,
    output int                            o_draws_due,
    output int                            o_mismatches
);
    import lfurng_pkg::*;

    localparam int unsigned LagWords = 97;
    localparam int unsigned ProductW = ScaleW + WordW;
    localparam logic [IdxW-1:0]  LagLongPos  = 7'd97;
    localparam logic [IdxW-1:0]  LagShortPos = 7'd33;
    localparam logic [WordW-1:0] CarryStart  = 24'd362436;
    localparam logic [WordW-1:0] CarryStep   = 24'd7654321;
    localparam logic [WordW-1:0] CarryFold   = 24'(32'd16777213 - 32'd7654321);

    typedef struct packed {
        logic [WordW-1:0]  uniform;
        logic [ScaleW-1:0] scaled;
    } t_draw_result;

    logic [SeedW-1:0] seed_a1, seed_a2, seed_a3, seed_b;
    logic [WordW-1:0] lag_words [LagWords];
    logic [IdxW-1:0]  lag_i, lag_j;
    logic [WordW-1:0] carry;
    t_draw_result     results_due [$];
    int               mismatch_count;

    function automatic logic [IdxW-1:0] step_lag(input logic [IdxW-1:0] idx);
        return (idx <= 1 || idx > LagWords) ? LagLongPos : idx - 1'b1;
    endfunction

    function automatic void restore_reset();
        seed_a1 = 8'd11;
        seed_a2 = 8'd33;
        seed_a3 = 8'd55;
        seed_b  = 8'd78;
        for (int w = 0; w < LagWords; w++) lag_words[w] = '0;
        lag_i = LagLongPos;
        lag_j = LagShortPos;
        carry = CarryStart;
    endfunction

    // Fill every word with 24 bits from the mod-179 product sequence and the
    // mod-169 linear sequence.
    function automatic void refill_lag_words();
        int unsigned m1, m2, m3, mb, nxt;
        logic [WordW-1:0] word;
        m1 = seed_a1 % 178 + 1;
        m2 = seed_a2 % 178 + 1;
        m3 = seed_a3 % 178 + 1;
        mb = seed_b % 169;
        if (m1 == 1 && m2 == 1 && m3 == 1) m1 = m1 + mb;
        for (int w = 0; w < LagWords; w++) begin
            word = '0;
            for (int k = 0; k < WordW; k++) begin
                nxt = (((m1 * m2) % 179) * m3) % 179;
                m1 = m2;
                m2 = m3;
                m3 = nxt;
                mb = (53 * mb + 1) % 169;
                word = {word[WordW-2:0], ((mb * nxt) % 64) > 31};
            end
            lag_words[w] = word;
        end
        lag_i = LagLongPos;
        lag_j = LagShortPos;
        carry = CarryStart;
    endfunction

    function automatic t_draw_result predict_draw(input logic [ScaleW-1:0] scale);
        t_draw_result     r;
        logic [WordW-1:0] diff;
        logic [ProductW-1:0] prod;
        // subtraction modulo 2^24 is exactly the wrap of a 24-bit difference
        diff = lag_words[lag_i - 1] - lag_words[lag_j - 1];
        lag_words[lag_i - 1] = diff;
        lag_i = step_lag(lag_i);
        lag_j = step_lag(lag_j);
        carry = (carry >= CarryStep) ? carry - CarryStep : carry + CarryFold;
        r.uniform = diff - carry;
        prod = ProductW'(scale) * ProductW'(r.uniform);
        r.scaled = ScaleW'(prod >> WordW);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_draw_result want;
        if (!i_rst_n) begin
            restore_reset();
            results_due.delete();
            mismatch_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_SEED_A1: seed_a1 = i_pwdata[SeedW-1:0];
                    REG_SEED_A2: seed_a2 = i_pwdata[SeedW-1:0];
                    REG_SEED_A3: seed_a3 = i_pwdata[SeedW-1:0];
                    REG_SEED_B:  seed_b  = i_pwdata[SeedW-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("draw result with no draw pending: uniform_value %0d",
                           i_uniform_value);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    if (i_uniform_value !== want.uniform) begin
                        $error("uniform_value: expected %0d, got %0d",
                               want.uniform, i_uniform_value);
                        mismatch_count++;
                    end
                    if (i_scaled_value !== want.scaled) begin
                        $error("scaled_value: expected %0d, got %0d",
                               want.scaled, i_scaled_value);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FUNC_DRAW) results_due.push_back(predict_draw(i_scale));
                else refill_lag_words();
            end
        end
        o_draws_due  <= results_due.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ===== test/tb_lagged_fibonacci_uniform_rng.sv =====
// Testbench top for lagged_fibonacci_uniform_rng: drives seed writes, reseed and
// draw beats with bursty timing and a stalling receiver, and reports the verdict.
// Depends on lfurng_pkg, the block itself and lfurng_draw_checker.
module tb_lagged_fibonacci_uniform_rng;
    import lfurng_pkg::*;

    // A reseed fills 97 words x 24 bits with no result; hold this long after one
    // before touching the seed registers.
    localparam int unsigned ReseedWait    = 19000;
    // Extra settling time at the very end.
    localparam int unsigned DrawSettle    = 32;
    localparam int unsigned RandomPhases  = 4;
    localparam int unsigned BeatsPerPhase = 132;
    localparam int unsigned ReseedCap     = 3;
    // Worst case: about 20 reseeds plus 8 reseed holds, and around 550 draws with
    // full gaps and stalls; allow ~5x their total.
    localparam int unsigned TimeoutCycles = 3000000;
    localparam logic [ScaleW-1:0] ScaleMax = '1;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_func;
    logic [ScaleW-1:0] i_scale;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [WordW-1:0]  o_uniform_value;
    logic [ScaleW-1:0] o_scaled_value;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                draws_due;
    int                mismatches;
    int unsigned       burst_left;
    int unsigned       stall_run = 0;
    logic              reseed_unsettled;

    lagged_fibonacci_uniform_rng dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_scale         (i_scale),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_uniform_value (o_uniform_value),
        .o_scaled_value  (o_scaled_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    lfurng_draw_checker draw_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_scale         (i_scale),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_uniform_value (o_uniform_value),
        .i_scaled_value  (o_scaled_value),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_draws_due     (draws_due),
        .o_mismatches    (mismatches)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver stall pattern: open stretches, solid blocks, and cycle-by-cycle
    // coin flips, each lasting a random while so stalls land on every draw phase.
    always @(posedge i_clk) begin
        int unsigned pick;
        if (stall_run == 0) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                i_out_stall <= 1'b0;
                stall_run   <= $urandom_range(20, 200);
            end else if (pick == 1) begin
                i_out_stall <= 1'b1;
                stall_run   <= $urandom_range(1, 12);
            end else begin
                i_out_stall <= 1'($urandom_range(0, 1));
                stall_run   <= 0;
            end
        end else begin
            stall_run <= stall_run - 1;
        end
    end

    // Present one beat and hold it until accepted; close the burst with a gap
    // of random length once its count runs out.
    task automatic put_beat(input logic func, input logic [ScaleW-1:0] scale);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_scale    <= scale;
        do @(posedge i_clk); while (o_in_stall);
        reseed_unsettled = (func == FUNC_RESEED);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and hold until the checker has nothing pending. The checker
    // registers the count it shows, so always step at least once.
    task automatic wait_results();
        if (i_in_valid) i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (draws_due != 0) @(posedge i_clk);
    endtask

    // Bring the block fully idle: results drained and any trailing reseed done.
    task automatic settle();
        wait_results();
        if (reseed_unsettled) repeat (ReseedWait) @(posedge i_clk);
        reseed_unsettled = 1'b0;
    endtask

    // Setup cycle, access cycle, then one idle cycle so back-to-back writes
    // never raise and drop psel in the same step.
    task automatic write_seed(input t_reg_idx idx, input logic [SeedW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // upper data bits are don't-care; toggle them now and then
        pwdata  <= {($urandom_range(0, 1) != 0) ? 24'($urandom()) : 24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_seeds(input logic [SeedW-1:0] a1, input logic [SeedW-1:0] a2,
                               input logic [SeedW-1:0] a3, input logic [SeedW-1:0] b);
        write_seed(REG_SEED_A1, a1);
        write_seed(REG_SEED_A2, a2);
        write_seed(REG_SEED_A3, a3);
        write_seed(REG_SEED_B, b);
    endtask

    function automatic logic [ScaleW-1:0] random_scale();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return ScaleMax;
        if (pick <= 3) return ScaleW'($urandom_range(0, 300));
        return ScaleW'($urandom());
    endfunction

    // Mostly in range, sometimes above it to exercise the modulo reduction.
    function automatic logic [SeedW-1:0] random_seed(input int unsigned top);
        if ($urandom_range(0, 9) > 6) return SeedW'($urandom_range(top + 1, 255));
        return SeedW'($urandom_range(0, top));
    endfunction

    // Either raw value reduces to a multiplicative seed of one.
    function automatic logic [SeedW-1:0] unit_seed();
        return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd178;
    endfunction

    initial begin
        int unsigned reseeds;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_func           = FUNC_DRAW;
        i_scale          = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        burst_left       = $urandom_range(1, 24);
        reseed_unsettled = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Draws straight out of reset run on the all-zero table.
        put_beat(FUNC_DRAW, '0);
        put_beat(FUNC_DRAW, ScaleMax);
        put_beat(FUNC_DRAW, 31'd1);
        // Reseed from the reset seeds, then draw across scale extremes.
        put_beat(FUNC_RESEED, ScaleMax);
        put_beat(FUNC_DRAW, ScaleMax);
        put_beat(FUNC_DRAW, '0);
        put_beat(FUNC_DRAW, 31'h2AAA_AAAA);
        put_beat(FUNC_DRAW, 31'h5555_5555);
        settle();

        // All three multiplicative seeds reduce to one: seed_b joins the first.
        write_seeds(8'd0, 8'd178, 8'd0, 8'd168);
        put_beat(FUNC_RESEED, '0);
        put_beat(FUNC_DRAW, ScaleMax);
        put_beat(FUNC_DRAW, 31'd1);
        settle();

        // Every register above its range.
        write_seeds(8'd255, 8'd255, 8'd255, 8'd255);
        put_beat(FUNC_RESEED, 31'd7);
        put_beat(FUNC_DRAW, ScaleMax);
        put_beat(FUNC_DRAW, 31'd12345);
        settle();

        // Largest in-range seeds.
        write_seeds(8'd177, 8'd177, 8'd177, 8'd168);
        put_beat(FUNC_RESEED, ScaleMax);
        put_beat(FUNC_DRAW, ScaleMax);
        put_beat(FUNC_DRAW, '0);
        settle();

        // Random phases: fresh seeds, usually a leading reseed, then draws with
        // the odd extra reseed and an occasional full drain.
        for (int ph = 0; ph < RandomPhases; ph++) begin
            reseeds = 0;
            if ($urandom_range(0, 3) == 0) begin
                write_seeds(unit_seed(), unit_seed(), unit_seed(), SeedW'($urandom()));
            end else begin
                write_seeds(random_seed(177), random_seed(177), random_seed(177),
                            random_seed(168));
            end
            if ($urandom_range(0, 3) != 0) put_beat(FUNC_RESEED, random_scale());
            for (int n = 0; n < BeatsPerPhase; n++) begin
                if (reseeds < ReseedCap && $urandom_range(0, 47) == 0) begin
                    put_beat(FUNC_RESEED, random_scale());
                    reseeds++;
                end else begin
                    put_beat(FUNC_DRAW, random_scale());
                end
                if ($urandom_range(0, 59) == 0) wait_results();
            end
            settle();
        end

        repeat (DrawSettle) @(posedge i_clk);
        if (mismatches == 0 && draws_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TimeoutCycles * 4);
        $display("status: fail");
        $finish;
    end

endmodule
